[hw/rtl/ftp_pkg.sv]
package ftp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned LINE_W  = 20;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned MAX_W   = 16;

    localparam logic [LINE_W-1:0]  LINE_SAT   = 20'hFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_SAT  = 17'h10000;
    localparam logic [MAX_W-1:0]   MAX_RESET  = 16'd2048;

    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_A_LOW  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    // Distance from 'a' back to the value ten.
    localparam logic [CHAR_W-1:0] HEX_ALPHA_OFS = 8'h57;

    typedef enum logic [0:0] {
        REQ_CHAR = 1'b0,
        REQ_END  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        SRC_LITERAL = 2'd0,
        SRC_RANDOM  = 2'd1,
        SRC_FRAME_N = 2'd2,
        SRC_FRAME_B = 2'd3
    } src_t;

    typedef enum logic [2:0] {
        ST_BUSY       = 3'd0,
        ST_DONE       = 3'd1,
        ST_TOO_LONG   = 3'd2,
        ST_BAD_RANDOM = 3'd3,
        ST_BAD_FRAME  = 3'd4,
        ST_INCOMPLETE = 3'd5,
        ST_INVALID    = 3'd6
    } status_t;

    typedef struct packed {
        logic               have_hi;
        logic [3:0]         hi_nib;
        logic               in_rand;
        logic               in_frame;
        logic               in_cmt;
        logic [LINE_W-1:0]  line_cnt;
        logic [COUNT_W-1:0] byte_cnt;
        status_t            err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        have_hi:  1'b0,
        hi_nib:   4'd0,
        in_rand:  1'b0,
        in_frame: 1'b0,
        in_cmt:   1'b0,
        line_cnt: 20'd1,
        byte_cnt: 17'd0,
        err:      ST_BUSY
    };

    typedef struct packed {
        logic               byte_valid;
        logic [7:0]         byte_value;
        src_t               byte_source;
        status_t            status;
        logic [LINE_W-1:0]  line_number;
        logic [COUNT_W-1:0] bytes_so_far;
    } parse_result_t;

endpackage

[hw/rtl/ftp_step.sv]
module ftp_step (
    input  ftp_pkg::parse_state_t          cur,
    input  ftp_pkg::req_t                  req_type,
    input  logic [7:0]                     character,
    input  logic [15:0]                    max_template_bytes,
    output ftp_pkg::parse_state_t          nxt,
    output ftp_pkg::parse_result_t         res
);
    import ftp_pkg::*;

    logic [CHAR_W-1:0]  c;
    logic               is_digit;
    logic               is_alpha_hex;
    logic               is_hex;
    logic [3:0]         hval;
    logic               is_blank;
    logic [LINE_W-1:0]  line_inc;
    logic [COUNT_W-1:0] byte_inc;
    logic [CHAR_W-1:0]  digit_ofs;
    logic [CHAR_W-1:0]  alpha_ofs;

    always_comb
    begin
        c = character;
        if (character inside {[8'h41:8'h5A]})
        begin
            c = character | CH_SPACE;
        end
        is_digit     = c inside {[8'h30:8'h39]};
        is_alpha_hex = c inside {[8'h61:8'h66]};
        is_hex       = is_digit || is_alpha_hex;
        digit_ofs    = c - CH_ZERO;
        alpha_ofs    = c - HEX_ALPHA_OFS;
        hval         = is_digit ? digit_ofs[3:0] : alpha_ofs[3:0];
        is_blank     = c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        line_inc     = (cur.line_cnt < LINE_SAT) ? cur.line_cnt + 1'b1 : cur.line_cnt;
        byte_inc     = (cur.byte_cnt < COUNT_SAT) ? cur.byte_cnt + 1'b1 : cur.byte_cnt;
    end

    always_comb
    begin
        nxt              = cur;
        res.byte_valid   = 1'b0;
        res.byte_value   = 8'd0;
        res.byte_source  = SRC_LITERAL;
        res.status       = cur.err;
        res.line_number  = cur.line_cnt;
        res.bytes_so_far = cur.byte_cnt;

        if (req_type == REQ_END)
        begin
            if (cur.err != ST_BUSY)
            begin
                res.status = cur.err;
            end
            else if (cur.byte_cnt > {1'b0, max_template_bytes})
            begin
                res.status = ST_TOO_LONG;
            end
            else
            begin
                res.status = ST_DONE;
            end
            nxt = STATE_RESET;
        end
        else if (cur.err == ST_BUSY)
        begin
            if (cur.in_rand)
            begin
                if (c != CH_X)
                begin
                    nxt.err = ST_BAD_RANDOM;
                end
                else
                begin
                    res.byte_valid  = 1'b1;
                    res.byte_source = SRC_RANDOM;
                    nxt.byte_cnt    = byte_inc;
                    nxt.in_rand     = 1'b0;
                end
            end
            else if (cur.in_frame)
            begin
                if (c != CH_N && c != CH_B)
                begin
                    nxt.err = ST_BAD_FRAME;
                end
                else
                begin
                    res.byte_valid  = 1'b1;
                    res.byte_source = (c == CH_N) ? SRC_FRAME_N : SRC_FRAME_B;
                    nxt.byte_cnt    = byte_inc;
                    nxt.in_frame    = 1'b0;
                end
            end
            else if (cur.in_cmt)
            begin
                if (c == CH_NL)
                begin
                    nxt.in_cmt   = 1'b0;
                    nxt.line_cnt = line_inc;
                end
            end
            else if (is_hex)
            begin
                if (cur.have_hi)
                begin
                    res.byte_valid = 1'b1;
                    res.byte_value = {cur.hi_nib, hval};
                    nxt.byte_cnt   = byte_inc;
                    nxt.have_hi    = 1'b0;
                    nxt.hi_nib     = 4'd0;
                end
                else
                begin
                    nxt.have_hi = 1'b1;
                    nxt.hi_nib  = hval;
                end
            end
            else if (cur.have_hi)
            begin
                nxt.err = ST_INCOMPLETE;
            end
            else if (c == CH_NL)
            begin
                nxt.line_cnt = line_inc;
            end
            else if (c == CH_HASH)
            begin
                nxt.in_cmt = 1'b1;
            end
            else if (c == CH_X)
            begin
                nxt.in_rand = 1'b1;
            end
            else if (c == CH_N)
            begin
                nxt.in_frame = 1'b1;
            end
            else if (!is_blank)
            begin
                nxt.err = ST_INVALID;
            end
            res.status       = nxt.err;
            res.line_number  = nxt.line_cnt;
            res.bytes_so_far = nxt.byte_cnt;
        end
    end

endmodule

[hw/rtl/frame_template_text_parser.sv]
// Channel   Direction  tdata                                  tuser
// s_axis    in         character[7:0]                         req_type[0]
// m_axis    out        byte_value, status, line, byte count   byte_valid, byte_source
// cfg_wr    in         max_template_bytes[15:0]               -
//
// Each item reaches the result register in the cycle after it is accepted, and one item
// can be accepted in every cycle while no result is stalled; the single output register sets that rate.
// The input side stalls only while a result waits and m_axis_tready is low.
// Reset clears the parse state, sets the byte limit to 2048 and empties the output.
module frame_template_text_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // character[7:0]
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // byte_value[7:0], status[10:8], line_number[30:11], bytes_so_far[47:31]
    output logic [47:0] m_axis_tdata,
    // byte_valid[0], byte_source[2:1]
    output logic [2:0]  m_axis_tuser,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import ftp_pkg::*;

    parse_state_t      state_reg;
    parse_state_t      state_next;
    parse_result_t     result_next;
    logic [MAX_W-1:0]  max_reg;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;
    logic [2:0]        out_user_reg;
    logic              accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ftp_step u_step (
        .cur                (state_reg),
        .req_type           (req_t'(s_axis_tuser[0])),
        .character          (s_axis_tdata),
        .max_template_bytes (max_reg),
        .nxt                (state_next),
        .res                (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            max_reg       <= MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {result_next.bytes_so_far, result_next.line_number,
                             result_next.status, result_next.byte_value};
            out_user_reg <= {result_next.byte_source, result_next.byte_valid};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

[hw/rtl/ftp_checker.sv]
module ftp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import ftp_pkg::*;

    // A produced byte is only possible while no error has been found.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[10:8] == ST_BUSY)
        else $error("byte produced with a nonzero status");

    // Without a byte, the value and source fields read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0
            && m_axis_tuser[2:1] == SRC_LITERAL)
        else $error("stray byte value or source without a byte");

    // The line count starts at one and never wraps to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:11] != 20'd0)
        else $error("line number is zero");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // The input side stalls only behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

endmodule

bind frame_template_text_parser ftp_checker u_ftp_checker (.*);
